// ===== hw/rtl/hsvr_pkg.sv =====
// Package for the HSV rainbow pixel renderer.
// Holds the register index codes, the hue section codes and the 8-bit scale helpers.
// No dependencies.
`timescale 1ns / 1ps

package hsvr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CORR_RED   = 3'd0;
    localparam logic [2:0] REG_CORR_GREEN = 3'd1;
    localparam logic [2:0] REG_CORR_BLUE  = 3'd2;
    localparam logic [2:0] REG_GLOBAL_SAT = 3'd3;
    localparam logic [2:0] REG_GLOBAL_BRT = 3'd4;
    localparam logic [2:0] REG_WHITE_PRES = 3'd5;

    // Hue sections, taken from the top three bits of hue
    localparam logic [2:0] SEC_RED    = 3'd0;
    localparam logic [2:0] SEC_ORANGE = 3'd1;
    localparam logic [2:0] SEC_YELLOW = 3'd2;
    localparam logic [2:0] SEC_GREEN  = 3'd3;
    localparam logic [2:0] SEC_AQUA   = 3'd4;
    localparam logic [2:0] SEC_BLUE   = 3'd5;
    localparam logic [2:0] SEC_PURPLE = 3'd6;
    localparam logic [2:0] SEC_PINK   = 3'd7;

    // Level constants of the rainbow map
    localparam logic [7:0] LVL_FULL    = 8'd255;
    localparam logic [7:0] LVL_TWO3    = 8'd171;
    localparam logic [7:0] LVL_TWO3_LO = 8'd170;
    localparam logic [7:0] LVL_ONE3    = 8'd85;

    // Reciprocal of three in 9 fractional bits
    localparam logic [8:0] RECIP3 = 9'd171;

    typedef logic [7:0] level_t;

    // (a*b)>>8 on 8-bit operands
    function automatic level_t mul8(input level_t a, input level_t b);
        logic [15:0] prod;
        prod = a * b;
        return prod[15:8];
    endfunction

    // x/3 for 8-bit x, exact over the full range
    function automatic level_t div3(input level_t x);
        logic [16:0] prod;
        prod = x * RECIP3;
        return prod[16:9];
    endfunction

endpackage

// ===== hw/rtl/hsv_rainbow_pixel_render.sv =====
// HSV rainbow pixel renderer top level: five-stage pipeline from HSV to RGBW levels.
// Depends on hsvr_pkg for codes and the 8-bit scale helpers.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------
//  input   | hue, pixel_saturation, pixel_value        | in_valid / in_stall
//  output  | red/green/blue/white_level                | out_valid / out_stall
//  config  | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// One word per clock while out_stall is low; a word passes stages 1 to 5 to out_valid.
// The pipeline depth is set by the chain of 8x8 scales: one multiply level per stage.
// Stages advance independently, so bubbles are squeezed out while the output stalls;
// in_stall rises only when every stage holds a word and out_stall is high.
// Reset clears all valid bits and loads the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module hsv_rainbow_pixel_render
(
    input  logic       clk,
    input  logic       rst_n,
    // input words
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] hue,
    input  logic [7:0] pixel_saturation,
    input  logic [7:0] pixel_value,
    // result words
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level,
    output logic [7:0] white_level,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers
    logic [7:0] corr_red_reg, corr_green_reg, corr_blue_reg;
    logic [7:0] global_sat_reg, global_brt_reg;
    logic       white_present_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_red_reg      <= hsvr_pkg::LVL_FULL;
            corr_green_reg    <= hsvr_pkg::LVL_FULL;
            corr_blue_reg     <= hsvr_pkg::LVL_FULL;
            global_sat_reg    <= hsvr_pkg::LVL_FULL;
            global_brt_reg    <= hsvr_pkg::LVL_FULL;
            white_present_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hsvr_pkg::REG_CORR_RED:   corr_red_reg      <= cfg_data;
                hsvr_pkg::REG_CORR_GREEN: corr_green_reg    <= cfg_data;
                hsvr_pkg::REG_CORR_BLUE:  corr_blue_reg     <= cfg_data;
                hsvr_pkg::REG_GLOBAL_SAT: global_sat_reg    <= cfg_data;
                hsvr_pkg::REG_GLOBAL_BRT: global_brt_reg    <= cfg_data;
                hsvr_pkg::REG_WHITE_PRES: white_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: scaled saturation, squared value, section and hue thirds
    logic [7:0] s1_sat_reg, s1_vsq_reg, s1_third_reg;
    logic [2:0] s1_sec_reg;
    logic [7:0] s1_sat_next, s1_vsq_next, s1_third_next;

    always_comb
    begin
        s1_sat_next   = hsvr_pkg::mul8(pixel_saturation, global_sat_reg);
        s1_vsq_next   = hsvr_pkg::mul8(pixel_value, pixel_value);
        s1_third_next = hsvr_pkg::div3({hue[4:0], 3'b000});
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sat_reg   <= s1_sat_next;
            s1_vsq_reg   <= s1_vsq_next;
            s1_third_reg <= s1_third_next;
            s1_sec_reg   <= hue[7:5];
        end
    end

    // Stage 2: rainbow levels, brightness scale, desaturation amount
    logic [7:0] s2_r_reg, s2_g_reg, s2_b_reg, s2_sat_reg, s2_d_reg, s2_val_reg;
    logic [7:0] s2_r_next, s2_g_next, s2_b_next, s2_d_next, s2_val_next;
    logic [7:0] vinc, twice, dbase;

    always_comb
    begin
        // nudge the square up by one strictly inside the range
        if (s1_vsq_reg != 8'd0 && s1_vsq_reg != hsvr_pkg::LVL_FULL)
            vinc = s1_vsq_reg + 8'd1;
        else
            vinc = s1_vsq_reg;
        s2_val_next = hsvr_pkg::mul8(vinc, global_brt_reg);

        dbase     = hsvr_pkg::LVL_FULL - s1_sat_reg;
        s2_d_next = hsvr_pkg::mul8(dbase, dbase);

        twice = {s1_third_reg[6:0], 1'b0};
        case (s1_sec_reg)
            hsvr_pkg::SEC_RED:
            begin
                s2_r_next = hsvr_pkg::LVL_FULL - s1_third_reg;
                s2_g_next = s1_third_reg;
                s2_b_next = 8'd0;
            end
            hsvr_pkg::SEC_ORANGE:
            begin
                s2_r_next = hsvr_pkg::LVL_TWO3;
                s2_g_next = hsvr_pkg::LVL_ONE3 + s1_third_reg;
                s2_b_next = 8'd0;
            end
            hsvr_pkg::SEC_YELLOW:
            begin
                s2_r_next = hsvr_pkg::LVL_TWO3 - twice;
                s2_g_next = hsvr_pkg::LVL_TWO3_LO + s1_third_reg;
                s2_b_next = 8'd0;
            end
            hsvr_pkg::SEC_GREEN:
            begin
                s2_r_next = 8'd0;
                s2_g_next = hsvr_pkg::LVL_FULL - s1_third_reg;
                s2_b_next = s1_third_reg;
            end
            hsvr_pkg::SEC_AQUA:
            begin
                s2_r_next = 8'd0;
                s2_g_next = hsvr_pkg::LVL_TWO3 - twice;
                s2_b_next = hsvr_pkg::LVL_ONE3 + twice;
            end
            hsvr_pkg::SEC_BLUE:
            begin
                s2_r_next = s1_third_reg;
                s2_g_next = 8'd0;
                s2_b_next = hsvr_pkg::LVL_FULL - s1_third_reg;
            end
            hsvr_pkg::SEC_PURPLE:
            begin
                s2_r_next = hsvr_pkg::LVL_ONE3 + s1_third_reg;
                s2_g_next = 8'd0;
                s2_b_next = hsvr_pkg::LVL_TWO3 - s1_third_reg;
            end
            hsvr_pkg::SEC_PINK:
            begin
                s2_r_next = hsvr_pkg::LVL_TWO3_LO + s1_third_reg;
                s2_g_next = 8'd0;
                s2_b_next = hsvr_pkg::LVL_ONE3 - s1_third_reg;
            end
            default:
            begin
                s2_r_next = 8'd0;
                s2_g_next = 8'd0;
                s2_b_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_r_reg   <= s2_r_next;
            s2_g_reg   <= s2_g_next;
            s2_b_reg   <= s2_b_next;
            s2_sat_reg <= s1_sat_reg;
            s2_d_reg   <= s2_d_next;
            s2_val_reg <= s2_val_next;
        end
    end

    // Stage 3: saturation scale, then white or RGB floor
    logic [7:0] s3_r_reg, s3_g_reg, s3_b_reg, s3_w_reg, s3_val_reg;
    logic [7:0] s3_r_next, s3_g_next, s3_b_next, s3_w_next;
    logic [7:0] rs, gs, bs;

    always_comb
    begin
        rs = hsvr_pkg::mul8(s2_r_reg, s2_sat_reg);
        gs = hsvr_pkg::mul8(s2_g_reg, s2_sat_reg);
        bs = hsvr_pkg::mul8(s2_b_reg, s2_sat_reg);
        s3_r_next = s2_r_reg;
        s3_g_next = s2_g_reg;
        s3_b_next = s2_b_reg;
        s3_w_next = 8'd0;
        if (s2_sat_reg == 8'd0)
        begin
            // fully desaturated: all white, or full RGB without white
            if (white_present_reg)
            begin
                s3_r_next = 8'd0;
                s3_g_next = 8'd0;
                s3_b_next = 8'd0;
                s3_w_next = hsvr_pkg::LVL_FULL;
            end
            else
            begin
                s3_r_next = hsvr_pkg::LVL_FULL;
                s3_g_next = hsvr_pkg::LVL_FULL;
                s3_b_next = hsvr_pkg::LVL_FULL;
            end
        end
        else if (s2_sat_reg != hsvr_pkg::LVL_FULL)
        begin
            if (white_present_reg)
            begin
                s3_r_next = rs;
                s3_g_next = gs;
                s3_b_next = bs;
                s3_w_next = s2_d_reg;
            end
            else
            begin
                // floor add wraps at 8 bits
                s3_r_next = rs + s2_d_reg;
                s3_g_next = gs + s2_d_reg;
                s3_b_next = bs + s2_d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_r_reg   <= s3_r_next;
            s3_g_reg   <= s3_g_next;
            s3_b_reg   <= s3_b_next;
            s3_w_reg   <= s3_w_next;
            s3_val_reg <= s2_val_reg;
        end
    end

    // Stage 4: value scale, skipped at full value
    logic [7:0] s4_r_reg, s4_g_reg, s4_b_reg, s4_w_reg;
    logic [7:0] s4_r_next, s4_g_next, s4_b_next, s4_w_next;

    always_comb
    begin
        if (s3_val_reg != hsvr_pkg::LVL_FULL)
        begin
            s4_r_next = hsvr_pkg::mul8(s3_r_reg, s3_val_reg);
            s4_g_next = hsvr_pkg::mul8(s3_g_reg, s3_val_reg);
            s4_b_next = hsvr_pkg::mul8(s3_b_reg, s3_val_reg);
            s4_w_next = hsvr_pkg::mul8(s3_w_reg, s3_val_reg);
        end
        else
        begin
            s4_r_next = s3_r_reg;
            s4_g_next = s3_g_reg;
            s4_b_next = s3_b_reg;
            s4_w_next = s3_w_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_r_reg <= s4_r_next;
            s4_g_reg <= s4_g_next;
            s4_b_reg <= s4_b_next;
            s4_w_reg <= s4_w_next;
        end
    end

    // Stage 5: color correction into the output register; white passes through
    logic [7:0] s5_r_reg, s5_g_reg, s5_b_reg, s5_w_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_r_reg <= hsvr_pkg::mul8(s4_r_reg, corr_red_reg);
            s5_g_reg <= hsvr_pkg::mul8(s4_g_reg, corr_green_reg);
            s5_b_reg <= hsvr_pkg::mul8(s4_b_reg, corr_blue_reg);
            s5_w_reg <= s4_w_reg;
        end
    end

    assign out_valid   = v5_reg;
    assign red_level   = s5_r_reg;
    assign green_level = s5_g_reg;
    assign blue_level  = s5_b_reg;
    assign white_level = s5_w_reg;

`ifndef SYNTH
    // back-pressure only when the output is blocked and every stage is full
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with room in the pipeline");

    // an accepted word lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted word not captured in stage one");

    // no white drive on an RGB strip
    a_no_white_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !white_present_reg) |-> (white_level == 8'd0))
        else $error("white level nonzero without white channel");

    // an idle output stage never blocks the stage behind it
    a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (!v5_reg && v4_reg) |=> v5_reg)
        else $error("word did not move into empty output stage");
`endif

endmodule

// ===== tb/sv/hsvr_level_checker.sv =====
// Level checker for the HSV rainbow pixel renderer: tracks register writes,
// predicts the RGBW levels of every accepted pixel and compares result words in order.
// Depends on hsvr_pkg for the register, section and level constants.
`timescale 1ns / 1ps

module hsvr_level_checker
(
    input  logic       clk,
    input  logic       rst_n,
    // pixel words into the block
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] hue,
    input  logic [7:0] pixel_saturation,
    input  logic [7:0] pixel_value,
    // level words out of the block
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] red_level,
    input  logic [7:0] green_level,
    input  logic [7:0] blue_level,
    input  logic [7:0] white_level,
    // register writes
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // status to the top
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        hsvr_pkg::level_t red;
        hsvr_pkg::level_t green;
        hsvr_pkg::level_t blue;
        hsvr_pkg::level_t white;
    } rgbw_t;

    // Shadow copy of the block's registers
    hsvr_pkg::level_t corr_red;
    hsvr_pkg::level_t corr_green;
    hsvr_pkg::level_t corr_blue;
    hsvr_pkg::level_t sat_scale;
    hsvr_pkg::level_t brt_scale;
    logic             white_on;

    rgbw_t  levels_q[$];
    int     mismatches;
    int     words_seen;

    // Fractional scale: (a*b)>>8
    function automatic hsvr_pkg::level_t frac_mul(input hsvr_pkg::level_t a,
                                                  input hsvr_pkg::level_t b);
        logic [15:0] prod;
        prod = a * b;
        return prod[15:8];
    endfunction

    // Expected drive levels for one pixel under the current registers
    function automatic rgbw_t render_pixel(input hsvr_pkg::level_t h,
                                           input hsvr_pkg::level_t s,
                                           input hsvr_pkg::level_t v);
        hsvr_pkg::level_t sat;
        hsvr_pkg::level_t val;
        hsvr_pkg::level_t third;
        hsvr_pkg::level_t desat;
        hsvr_pkg::level_t r;
        hsvr_pkg::level_t g;
        hsvr_pkg::level_t b;
        hsvr_pkg::level_t w;
        rgbw_t            res;

        sat = frac_mul(s, sat_scale);
        // squared value, bumped by one off the ends, then brightness
        val = frac_mul(v, v);
        if (val != 8'd0 && val != hsvr_pkg::LVL_FULL)
            val = val + 8'd1;
        val = frac_mul(val, brt_scale);

        // offset within the section, 0..82
        third = {h[4:0], 3'b000} / 8'd3;
        w = 8'd0;

        case (h[7:5])
            hsvr_pkg::SEC_RED:
            begin
                r = hsvr_pkg::LVL_FULL - third;
                g = third;
                b = 8'd0;
            end
            hsvr_pkg::SEC_ORANGE:
            begin
                r = hsvr_pkg::LVL_TWO3;
                g = hsvr_pkg::LVL_ONE3 + third;
                b = 8'd0;
            end
            hsvr_pkg::SEC_YELLOW:
            begin
                r = hsvr_pkg::LVL_TWO3 - (third << 1);
                g = hsvr_pkg::LVL_TWO3_LO + third;
                b = 8'd0;
            end
            hsvr_pkg::SEC_GREEN:
            begin
                r = 8'd0;
                g = hsvr_pkg::LVL_FULL - third;
                b = third;
            end
            hsvr_pkg::SEC_AQUA:
            begin
                r = 8'd0;
                g = hsvr_pkg::LVL_TWO3 - (third << 1);
                b = hsvr_pkg::LVL_ONE3 + (third << 1);
            end
            hsvr_pkg::SEC_BLUE:
            begin
                r = third;
                g = 8'd0;
                b = hsvr_pkg::LVL_FULL - third;
            end
            hsvr_pkg::SEC_PURPLE:
            begin
                r = hsvr_pkg::LVL_ONE3 + third;
                g = 8'd0;
                b = hsvr_pkg::LVL_TWO3 - third;
            end
            default:
            begin
                r = hsvr_pkg::LVL_TWO3_LO + third;
                g = 8'd0;
                b = hsvr_pkg::LVL_ONE3 - third;
            end
        endcase

        // desaturation: to white on RGBW strips, as a floor on RGB strips
        if (sat != hsvr_pkg::LVL_FULL)
        begin
            if (sat == 8'd0)
            begin
                if (white_on)
                begin
                    r = 8'd0;
                    g = 8'd0;
                    b = 8'd0;
                    w = hsvr_pkg::LVL_FULL;
                end
                else
                begin
                    r = hsvr_pkg::LVL_FULL;
                    g = hsvr_pkg::LVL_FULL;
                    b = hsvr_pkg::LVL_FULL;
                end
            end
            else
            begin
                desat = hsvr_pkg::LVL_FULL - sat;
                desat = frac_mul(desat, desat);
                r = frac_mul(r, sat);
                g = frac_mul(g, sat);
                b = frac_mul(b, sat);
                if (white_on)
                    w = desat;
                else
                begin
                    r = r + desat;
                    g = g + desat;
                    b = b + desat;
                end
            end
        end

        // value scaling hits white too; correction does not
        if (val != hsvr_pkg::LVL_FULL)
        begin
            r = frac_mul(r, val);
            g = frac_mul(g, val);
            b = frac_mul(b, val);
            w = frac_mul(w, val);
        end

        res.red   = frac_mul(r, corr_red);
        res.green = frac_mul(g, corr_green);
        res.blue  = frac_mul(b, corr_blue);
        res.white = w;
        return res;
    endfunction

    // Watch all three channels; results are retired before new pixels are queued
    always @(posedge clk or negedge rst_n)
    begin : track
        rgbw_t want;
        rgbw_t got;

        if (!rst_n)
        begin
            corr_red   = hsvr_pkg::LVL_FULL;
            corr_green = hsvr_pkg::LVL_FULL;
            corr_blue  = hsvr_pkg::LVL_FULL;
            sat_scale  = hsvr_pkg::LVL_FULL;
            brt_scale  = hsvr_pkg::LVL_FULL;
            white_on   = 1'b0;
            levels_q.delete();
            mismatches = 0;
            words_seen = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // register write; spare indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hsvr_pkg::REG_CORR_RED:   corr_red   = cfg_data;
                    hsvr_pkg::REG_CORR_GREEN: corr_green = cfg_data;
                    hsvr_pkg::REG_CORR_BLUE:  corr_blue  = cfg_data;
                    hsvr_pkg::REG_GLOBAL_SAT: sat_scale  = cfg_data;
                    hsvr_pkg::REG_GLOBAL_BRT: brt_scale  = cfg_data;
                    hsvr_pkg::REG_WHITE_PRES: white_on   = cfg_data[0];
                    default: ;
                endcase
            end

            // result word against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = {red_level, green_level, blue_level, white_level};
                if (levels_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: unexpected r=%0d g=%0d b=%0d w=%0d",
                                 words_seen, got.red, got.green, got.blue, got.white);
                end
                else
                begin
                    want = levels_q.pop_front();
                    if (got.red != want.red || got.green != want.green ||
                        got.blue != want.blue || got.white != want.white)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                     words_seen, want.red, want.green, want.blue,
                                     want.white, got.red, got.green, got.blue,
                                     got.white);
                    end
                end
                words_seen++;
            end

            // pixel word in
            if (in_valid && !in_stall)
                levels_q.push_back(render_pixel(hue, pixel_saturation, pixel_value));

            fail_count <= mismatches;
            pending    <= levels_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the HSV rainbow pixel renderer testbench: clock, reset, register setup,
// directed and random pixel words, random idling on both sides, and the verdict.
// Depends on hsvr_pkg, hsv_rainbow_pixel_render and hsvr_level_checker.
`timescale 1ns / 1ps

module tb_top;

    // Indexes past the last register; writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] hue;
    logic [7:0] pixel_saturation;
    logic [7:0] pixel_value;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] white_level;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic idle_on     = 1'b0;

    hsv_rainbow_pixel_render u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .hue              (hue),
        .pixel_saturation (pixel_saturation),
        .pixel_value      (pixel_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level),
        .white_level      (white_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    hsvr_level_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .hue              (hue),
        .pixel_saturation (pixel_saturation),
        .pixel_value      (pixel_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level),
        .white_level      (white_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Output stall in random bursts, started only while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // One pixel word, with an optional gap ahead of it; returns on the accepting edge
    task automatic push_pixel(input hsvr_pkg::level_t h, input hsvr_pkg::level_t s,
                              input hsvr_pkg::level_t v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        hue              <= h;
        pixel_saturation <= s;
        pixel_value      <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Full register set plus one write to a spare index
    task automatic load_regs(input hsvr_pkg::level_t cr, input hsvr_pkg::level_t cg,
                             input hsvr_pkg::level_t cb, input hsvr_pkg::level_t gs,
                             input hsvr_pkg::level_t gb, input logic [7:0] wd);
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
        write_reg(hsvr_pkg::REG_CORR_RED, cr);
        write_reg(hsvr_pkg::REG_CORR_GREEN, cg);
        write_reg(hsvr_pkg::REG_CORR_BLUE, cb);
        write_reg(hsvr_pkg::REG_GLOBAL_SAT, gs);
        write_reg(hsvr_pkg::REG_GLOBAL_BRT, gb);
        write_reg(hsvr_pkg::REG_WHITE_PRES, wd);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        hsvr_pkg::level_t h;
        hsvr_pkg::level_t s;
        hsvr_pkg::level_t v;
        int               p;
        int               k;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        hue              = 8'd0;
        pixel_saturation = 8'd0;
        pixel_value      = 8'd0;
        out_stall        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = hsvr_pkg::REG_CORR_RED;
        cfg_data         = 8'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers, RGB strip: section edges, hue extremes, saturation and value corners
        push_pixel(8'd0,   8'd255, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd32,  8'd255, 8'd255);
        push_pixel(8'd64,  8'd255, 8'd255);
        push_pixel(8'd96,  8'd255, 8'd255);
        push_pixel(8'd128, 8'd255, 8'd255);
        push_pixel(8'd160, 8'd255, 8'd255);
        push_pixel(8'd192, 8'd255, 8'd255);
        push_pixel(8'd224, 8'd255, 8'd255);
        push_pixel(8'd31,  8'd200, 8'd200);
        push_pixel(8'd127, 8'd128, 8'd16);
        push_pixel(8'd0,   8'd0,   8'd255);   // no saturation, RGB floor at full
        push_pixel(8'd200, 8'd1,   8'd255);   // saturation scales to zero
        push_pixel(8'd77,  8'd255, 8'd0);     // value zero
        push_pixel(8'd77,  8'd255, 8'd1);
        push_pixel(8'd77,  8'd255, 8'd15);
        push_pixel(8'd160, 8'd128, 8'd128);
        wait_drained();

        // White channel on; upper data bits must be dropped
        load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFB);
        push_pixel(8'd0,   8'd0,   8'd255);   // no saturation goes fully to white
        push_pixel(8'd99,  8'd0,   8'd100);
        push_pixel(8'd255, 8'd128, 8'd255);
        push_pixel(8'd10,  8'd255, 8'd0);

        // Random phases; one without idling in the middle, none in the last two
        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            case (p)
                0: load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
                1: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
                2: load_regs(8'd1, 8'd128, 8'd254, 8'd1, 8'd255, 8'h02);
                default: load_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            idle_on <= (p != 3) && (p < 6);

            for (k = 0; k < 48; k++)
            begin
                h = 8'($urandom);
                case ($urandom_range(0, 7))
                    0:       s = 8'd0;
                    1:       s = 8'd1;
                    2:       s = 8'd255;
                    default: s = 8'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       v = 8'd0;
                    1:       v = 8'($urandom_range(1, 16));
                    2:       v = 8'd255;
                    default: v = 8'($urandom);
                endcase
                push_pixel(h, s, v);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
